[src/pcds_pkg.sv]
// package for the pwm clock divider search block
// holds the sequencer state type and the fixed constants, no dependencies
package pcds_pkg;

  localparam int unsigned FreqW     = 23;
  localparam int unsigned ClkW      = 32;
  localparam int unsigned TargetW   = 33;
  localparam int unsigned PreW      = 8;
  localparam int unsigned ExpW      = 4;
  localparam int unsigned CntW      = $clog2(ClkW);

  localparam logic [ClkW-1:0] MasterClockReset = 32'd48000000;
  localparam logic [ExpW-1:0] ExpMax           = 4'd10;
  localparam logic [CntW-1:0] DivLastBit       = CntW'(ClkW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SRCH,
    ST_FIN
  } state_e;

endpackage

[src/pwm_clock_divider_search.sv]
// pwm clock divider search: picks prescaler and power-of-two exponent for a frequency
// single-module design, uses pcds_pkg
//
// Each request runs one at a time. After acceptance the target clock (frequency times
// 1000) is started at acceptance and finished in ST_MUL, then a restoring divider
// produces master_clock / target one quotient bit per cycle, then the quotient is
// shifted right one place per cycle until it fits in 8 bits or the exponent reaches 10
// (the setting then fails), and the result is registered once the output register is
// free. A zero frequency skips the divider and fails. The input is taken again once
// the result has been handed to the output register, even while that result is still
// stalled. master_clock may only be written while no item is in flight.
module pwm_clock_divider_search
  import pcds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ClkW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FreqW-1:0]  requested_frequency_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              setting_ok_o,
  output logic [PreW-1:0]   prescaler_o,
  output logic [ExpW-1:0]   divisor_exponent_o
);

  state_e               state_q, state_d;
  logic [ClkW-1:0]      master_q;
  logic [FreqW-1:0]     freq_q;
  logic [TargetW-1:0]   t_q;
  logic [TargetW-1:0]   r_q;
  logic [ClkW-1:0]      m_q;
  logic [CntW-1:0]      cnt_q;
  logic [ExpW-1:0]      d_q;
  logic                 ok_q;
  logic                 out_valid_q;
  logic                 setting_ok_q;
  logic [PreW-1:0]      prescaler_q;
  logic [ExpW-1:0]      exponent_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;
  logic [TargetW:0]     rem_sh;
  logic [TargetW-1:0]   rem_diff;
  logic                 q_bit;
  logic                 fits;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign rem_sh   = {r_q, m_q[ClkW-1]};
  assign rem_diff = rem_sh[TargetW-1:0] - t_q;
  assign q_bit    = (rem_sh >= {1'b0, t_q});
  assign fits     = (m_q[ClkW-1:PreW] == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (freq_q == '0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (fits || (d_q == ExpMax)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_FIN:  load_out   = out_free;
      default: begin
        in_stall_o = 1'b1;
        load_out   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      master_q    <= MasterClockReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        master_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          freq_q <= requested_frequency_i;
          // 1000 = 1024 - 16 - 8, second subtraction in the next cycle
          t_q    <= {requested_frequency_i, 10'd0} - {6'd0, requested_frequency_i, 4'd0};
          r_q    <= '0;
          m_q    <= master_q;
          cnt_q  <= DivLastBit;
          d_q    <= '0;
          ok_q   <= 1'b0;
        end
      end
      ST_MUL: begin
        t_q <= t_q - {7'd0, freq_q, 3'd0};
      end
      ST_DIV: begin
        if (q_bit) begin
          r_q <= rem_diff;
        end else begin
          r_q <= rem_sh[TargetW-1:0];
        end
        m_q   <= {m_q[ClkW-2:0], q_bit};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_SRCH: begin
        if (fits) begin
          // a zero quotient can only occur at exponent zero
          ok_q <= (m_q != '0);
        end else if (d_q != ExpMax) begin
          m_q <= {1'b0, m_q[ClkW-1:1]};
          d_q <= d_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      setting_ok_q <= ok_q;
      prescaler_q  <= ok_q ? m_q[PreW-1:0] : '0;
      exponent_q   <= ok_q ? d_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign setting_ok_o       = setting_ok_q;
  assign prescaler_o        = prescaler_q;
  assign divisor_exponent_o = exponent_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !setting_ok_o |-> (prescaler_o == '0) && (divisor_exponent_o == '0))
    else $error("failed setting carries nonzero fields");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && setting_ok_o |-> divisor_exponent_o <= ExpMax)
    else $error("divisor exponent out of range");

  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MUL)
    else $error("accepted item did not start");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> t_q != '0)
    else $error("division by zero target");

endmodule
